// ===== rtl/cdq_pkg.sv =====
// Shared types and codes for the circular deque unit.
// Depends on nothing; used by cdq_cell and circular_deque_unit.
package cdq_pkg;

   localparam int unsigned WORD_W   = 32;
   localparam int unsigned ACTION_W = 3;
   localparam int unsigned STATUS_W = 2;
   localparam int unsigned CAP_W    = 5;
   localparam int unsigned CSR_W    = 32;
   localparam int unsigned ADDR_W   = 2;

   // Action codes
   localparam logic [ACTION_W-1:0] ACT_PUSH_FRONT = 3'd0;
   localparam logic [ACTION_W-1:0] ACT_PUSH_REAR  = 3'd1;
   localparam logic [ACTION_W-1:0] ACT_POP_FRONT  = 3'd2;
   localparam logic [ACTION_W-1:0] ACT_POP_REAR   = 3'd3;
   localparam logic [ACTION_W-1:0] ACT_PEEK_FRONT = 3'd4;
   localparam logic [ACTION_W-1:0] ACT_PEEK_REAR  = 3'd5;

   // Status codes
   localparam logic [STATUS_W-1:0] STS_DONE  = 2'd0;
   localparam logic [STATUS_W-1:0] STS_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] STS_EMPTY = 2'd2;

   // Register addresses
   localparam logic [ADDR_W-1:0] REG_CAPACITY = 2'd0;
   localparam logic [CAP_W-1:0]  CAPACITY_RST = 5'd16;

   // Per-cycle command broadcast to every cell of the chain
   typedef struct packed {
      logic clear;
      logic shift_right;
      logic shift_left;
      logic load_rear;
      logic drop_rear;
   } cdq_ctrl_type;

endpackage

// ===== rtl/cdq_cell.sv =====
// One slot of the deque chain: a word and its occupied bit.
// Depends on cdq_pkg; trades words with its left and right neighbors.
module cdq_cell (
   input  logic                               clock,
   input  logic                               reset,
   input  cdq_pkg::cdq_ctrl_type              ctrl,
   input  logic signed [cdq_pkg::WORD_W-1:0]  push_word,
   input  logic                               left_valid,
   input  logic signed [cdq_pkg::WORD_W-1:0]  left_data,
   input  logic                               right_valid,
   input  logic signed [cdq_pkg::WORD_W-1:0]  right_data,
   output logic                               valid,
   output logic signed [cdq_pkg::WORD_W-1:0]  data
);

   logic                              valid_ff;
   logic                              valid_in;
   logic signed [cdq_pkg::WORD_W-1:0] data_ff;
   logic signed [cdq_pkg::WORD_W-1:0] data_in;

   // Pick the next slot contents from the broadcast command
   always_comb begin
      data_in  = data_ff;
      valid_in = valid_ff;
      if (ctrl.clear) begin
         valid_in = 1'b0;
      end else if (ctrl.shift_right) begin
         data_in  = left_data;
         valid_in = left_valid;
      end else if (ctrl.shift_left) begin
         data_in  = right_data;
         valid_in = right_valid;
      end else if (ctrl.load_rear && !valid_ff && left_valid) begin
         data_in  = push_word;
         valid_in = 1'b1;
      end else if (ctrl.drop_rear && valid_ff && !right_valid) begin
         valid_in = 1'b0;
      end
   end

   // Hold the occupied bit under reset; the word needs none
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign valid = valid_ff;
   assign data  = data_ff;

endmodule

// ===== rtl/circular_deque_unit.sv =====
// Top level of the circular deque: control, fill count, result register, CSR.
// Depends on cdq_pkg and cdq_cell.
//
//  channel   direction  handshake            payload
//  request   in         start & !busy        req_action, req_data_value
//  result    out        rsp_valid (1 cycle)  rsp_status, rsp_read_value,
//                                            rsp_now_empty, rsp_now_full
//  csr       in/out     psel&penable&pwrite  paddr, pwdata, prdata
//
// One transaction per cycle: busy stays low, the result appears the cycle
// after start, held in the result register beside the cell chain.
// The front word always sits in cell 0; the rear is the last occupied cell.
// Synchronous reset empties the deque and sets capacity to 16; no clearing
// pass is needed. The receiver cannot stall; a capacity write empties the deque.
module circular_deque_unit #(
   parameter int unsigned DEPTH = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic [cdq_pkg::ACTION_W-1:0]         req_action,
   input  logic signed [cdq_pkg::WORD_W-1:0]    req_data_value,
   output logic                                 rsp_valid,
   output logic [cdq_pkg::STATUS_W-1:0]         rsp_status,
   output logic signed [cdq_pkg::WORD_W-1:0]    rsp_read_value,
   output logic                                 rsp_now_empty,
   output logic                                 rsp_now_full,
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [cdq_pkg::ADDR_W-1:0]           paddr,
   input  logic [cdq_pkg::CSR_W-1:0]            pwdata,
   output logic [cdq_pkg::CSR_W-1:0]            prdata,
   output logic                                 pready
);

   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam int unsigned CMP_W = (CNT_W > cdq_pkg::CAP_W) ? CNT_W : cdq_pkg::CAP_W;

   logic [cdq_pkg::CAP_W-1:0] capacity_ff;
   logic [cdq_pkg::CAP_W-1:0] capacity_in;
   logic [CNT_W-1:0]          count_ff;
   logic [CNT_W-1:0]          count_in;
   logic                      csr_write;
   logic                      accept;

   logic [CMP_W-1:0] cap_ext;
   logic [CMP_W-1:0] cap_eff;
   logic [CMP_W-1:0] count_ext;
   logic [CMP_W-1:0] count_next_ext;
   logic             is_empty;
   logic             is_full;

   cdq_pkg::cdq_ctrl_type ctrl;

   logic                              cell_valid [DEPTH];
   logic signed [cdq_pkg::WORD_W-1:0] cell_data  [DEPTH];
   logic                              rear_hit   [DEPTH];
   logic signed [cdq_pkg::WORD_W-1:0] rear_word;

   logic [cdq_pkg::STATUS_W-1:0]      status_in;
   logic signed [cdq_pkg::WORD_W-1:0] read_in;

   logic                              rsp_valid_ff;
   logic [cdq_pkg::STATUS_W-1:0]      status_ff;
   logic signed [cdq_pkg::WORD_W-1:0] read_ff;
   logic                              empty_ff;
   logic                              full_ff;

   assign busy      = 1'b0;
   assign accept    = start && !busy;
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready && (paddr == cdq_pkg::REG_CAPACITY);
   assign prdata    = cdq_pkg::CSR_W'(capacity_ff);

   // Clamp capacity into 1..DEPTH
   always_comb begin
      cap_ext = CMP_W'(capacity_ff);
      if (cap_ext == '0) begin
         cap_eff = CMP_W'(1);
      end else if (cap_ext > CMP_W'(DEPTH)) begin
         cap_eff = CMP_W'(DEPTH);
      end else begin
         cap_eff = cap_ext;
      end
   end

   assign count_ext = CMP_W'(count_ff);
   assign is_empty  = (count_ff == '0);
   assign is_full   = (count_ext == cap_eff);

   // Find the rear word: the last occupied cell
   generate
      for (genvar i = 0; i < DEPTH; i++) begin : g_rear
         if (i == DEPTH - 1) begin : g_last
            assign rear_hit[i] = cell_valid[i];
         end else begin : g_mid
            assign rear_hit[i] = cell_valid[i] && !cell_valid[i+1];
         end
      end
   endgenerate

   always_comb begin
      rear_word = '0;
      for (int i = 0; i < DEPTH; i++) begin
         rear_word = rear_word | (rear_hit[i] ? cell_data[i] : '0);
      end
   end

   // Decode the action into a chain command, status and read word
   always_comb begin
      ctrl           = '0;
      ctrl.clear     = csr_write;
      status_in      = cdq_pkg::STS_DONE;
      read_in        = '0;
      count_in       = count_ff;
      capacity_in    = capacity_ff;
      if (csr_write) begin
         capacity_in = pwdata[cdq_pkg::CAP_W-1:0];
         count_in    = '0;
      end else if (accept) begin
         unique case (req_action)
            cdq_pkg::ACT_PUSH_FRONT, cdq_pkg::ACT_PUSH_REAR: begin
               if (is_full) begin
                  status_in = cdq_pkg::STS_FULL;
               end else begin
                  ctrl.shift_right = (req_action == cdq_pkg::ACT_PUSH_FRONT);
                  ctrl.load_rear   = (req_action == cdq_pkg::ACT_PUSH_REAR);
                  count_in         = count_ff + CNT_W'(1);
               end
            end
            cdq_pkg::ACT_POP_FRONT, cdq_pkg::ACT_POP_REAR: begin
               if (is_empty) begin
                  status_in = cdq_pkg::STS_EMPTY;
               end else begin
                  ctrl.shift_left = (req_action == cdq_pkg::ACT_POP_FRONT);
                  ctrl.drop_rear  = (req_action == cdq_pkg::ACT_POP_REAR);
                  read_in  = (req_action == cdq_pkg::ACT_POP_FRONT) ? cell_data[0] : rear_word;
                  count_in = count_ff - CNT_W'(1);
               end
            end
            cdq_pkg::ACT_PEEK_FRONT, cdq_pkg::ACT_PEEK_REAR: begin
               if (is_empty) begin
                  status_in = cdq_pkg::STS_EMPTY;
               end else begin
                  read_in = (req_action == cdq_pkg::ACT_PEEK_FRONT) ? cell_data[0] : rear_word;
               end
            end
            default: begin
               status_in = cdq_pkg::STS_DONE;
            end
         endcase
      end
   end

   assign count_next_ext = CMP_W'(count_in);

   // Chain of cells; cell 0 sees the push word on its left
   generate
      for (genvar i = 0; i < DEPTH; i++) begin : g_cell
         logic                              lv;
         logic signed [cdq_pkg::WORD_W-1:0] ld;
         logic                              rv;
         logic signed [cdq_pkg::WORD_W-1:0] rd;
         if (i == 0) begin : g_left_edge
            assign lv = 1'b1;
            assign ld = req_data_value;
         end else begin : g_left_mid
            assign lv = cell_valid[i-1];
            assign ld = cell_data[i-1];
         end
         if (i == DEPTH - 1) begin : g_right_edge
            assign rv = 1'b0;
            assign rd = '0;
         end else begin : g_right_mid
            assign rv = cell_valid[i+1];
            assign rd = cell_data[i+1];
         end
         cdq_cell u_cell (
            .clock       (clock),
            .reset       (reset),
            .ctrl        (ctrl),
            .push_word   (req_data_value),
            .left_valid  (lv),
            .left_data   (ld),
            .right_valid (rv),
            .right_data  (rd),
            .valid       (cell_valid[i]),
            .data        (cell_data[i])
         );
      end
   endgenerate

   // Advance fill count, capacity and result strobe
   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff  <= cdq_pkg::CAPACITY_RST;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         capacity_ff  <= capacity_in;
         count_ff     <= count_in;
         rsp_valid_ff <= accept;
      end
   end

   // Hold the result payload until the next accepted transaction
   always_ff @(posedge clock) begin
      if (accept) begin
         status_ff <= status_in;
         read_ff   <= read_in;
         empty_ff  <= (count_in == '0);
         full_ff   <= (count_next_ext == cap_eff);
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = status_ff;
   assign rsp_read_value = read_ff;
   assign rsp_now_empty  = empty_ff;
   assign rsp_now_full   = full_ff;

   // Fill count agrees with the front cell's occupied bit
   a_count_front: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) == !cell_valid[0])
      else $error("fill count disagrees with front cell");

   // Fill count never exceeds the capacity in use
   a_count_cap: assert property (@(posedge clock) disable iff (reset)
      count_ext <= cap_eff)
      else $error("fill count above capacity");

   // Every accepted transaction yields one result strobe next cycle
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid)
      else $error("missing result strobe");

   // A refused transaction leaves the fill count alone
   a_refused_stable: assert property (@(posedge clock) disable iff (reset)
      (accept && !csr_write && status_in != cdq_pkg::STS_DONE) |=> $stable(count_ff))
      else $error("refused transaction changed fill count");

endmodule

// ===== sim/deque_checker.sv =====
`timescale 1ns / 1ps
// Checker for circular_deque_unit: watches the request, result and CSR channels,
// predicts every result with its own deque model and compares field by field.
// Depends on cdq_pkg for widths, action, status and register codes.
module deque_checker #(
   parameter int unsigned DEPTH = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   input  logic                                 busy,
   input  logic [cdq_pkg::ACTION_W-1:0]         req_action,
   input  logic signed [cdq_pkg::WORD_W-1:0]    req_data_value,
   input  logic                                 rsp_valid,
   input  logic [cdq_pkg::STATUS_W-1:0]         rsp_status,
   input  logic signed [cdq_pkg::WORD_W-1:0]    rsp_read_value,
   input  logic                                 rsp_now_empty,
   input  logic                                 rsp_now_full,
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [cdq_pkg::ADDR_W-1:0]           paddr,
   input  logic [cdq_pkg::CSR_W-1:0]            pwdata,
   input  logic [cdq_pkg::CSR_W-1:0]            prdata,
   input  logic                                 pready,
   output int unsigned                          mismatch_count,
   output int unsigned                          pending_count
);

   typedef struct packed {
      logic [cdq_pkg::STATUS_W-1:0] status;
      logic [cdq_pkg::WORD_W-1:0]   read_value;
      logic                         now_empty;
      logic                         now_full;
   } deque_outcome_type;

   // Predicted deque contents and pointers
   logic [cdq_pkg::WORD_W-1:0] ring_words [DEPTH];
   int unsigned                front_slot;
   int unsigned                rear_slot;
   logic                       deque_empty;
   logic [cdq_pkg::CAP_W-1:0]  capacity_reg;

   // Results predicted but not yet seen, oldest first
   deque_outcome_type          awaited_outcomes[$];

   // Clamp the programmed capacity to 1..DEPTH
   function automatic int unsigned slots_in_use();
      int unsigned c;
      c = 32'(capacity_reg);
      if (c == 0) c = 1;
      if (c > DEPTH) c = DEPTH;
      return c;
   endfunction

   function automatic int unsigned step_up(input int unsigned i, input int unsigned c);
      return (i + 1 >= c) ? 0 : i + 1;
   endfunction

   function automatic int unsigned step_down(input int unsigned i, input int unsigned c);
      return (i == 0 || i >= c) ? c - 1 : i - 1;
   endfunction

   function automatic logic ring_full(input int unsigned c);
      return !deque_empty && step_up(rear_slot, c) == front_slot;
   endfunction

   function automatic void empty_deque();
      front_slot  = 0;
      rear_slot   = 0;
      deque_empty = 1'b1;
   endfunction

   // Apply one action to the predicted deque and return the result it yields
   function automatic deque_outcome_type deque_step_outcome(
         input logic [cdq_pkg::ACTION_W-1:0] act,
         input logic [cdq_pkg::WORD_W-1:0]   word);
      deque_outcome_type o;
      int unsigned       c;
      c = slots_in_use();
      o = '0;
      o.status = cdq_pkg::STS_DONE;
      case (act)
         cdq_pkg::ACT_PUSH_FRONT, cdq_pkg::ACT_PUSH_REAR: begin
            if (ring_full(c)) begin
               o.status = cdq_pkg::STS_FULL;
            end else if (deque_empty) begin
               front_slot    = 0;
               rear_slot     = 0;
               deque_empty   = 1'b0;
               ring_words[0] = word;
            end else if (act == cdq_pkg::ACT_PUSH_FRONT) begin
               front_slot             = step_down(front_slot, c);
               ring_words[front_slot] = word;
            end else begin
               rear_slot             = step_up(rear_slot, c);
               ring_words[rear_slot] = word;
            end
         end
         cdq_pkg::ACT_POP_FRONT, cdq_pkg::ACT_POP_REAR: begin
            if (deque_empty) begin
               o.status = cdq_pkg::STS_EMPTY;
            end else begin
               o.read_value =
                  ring_words[act == cdq_pkg::ACT_POP_FRONT ? front_slot : rear_slot];
               if (front_slot == rear_slot) begin
                  empty_deque();
               end else if (act == cdq_pkg::ACT_POP_FRONT) begin
                  front_slot = step_up(front_slot, c);
               end else begin
                  rear_slot = step_down(rear_slot, c);
               end
            end
         end
         cdq_pkg::ACT_PEEK_FRONT, cdq_pkg::ACT_PEEK_REAR: begin
            if (deque_empty) begin
               o.status = cdq_pkg::STS_EMPTY;
            end else begin
               o.read_value =
                  ring_words[act == cdq_pkg::ACT_PEEK_FRONT ? front_slot : rear_slot];
            end
         end
         default: ;
      endcase
      o.now_empty = deque_empty;
      o.now_full  = ring_full(c);
      return o;
   endfunction

   always @(posedge clock) begin
      deque_outcome_type want;
      if (reset) begin
         capacity_reg = cdq_pkg::CAPACITY_RST;
         empty_deque();
         awaited_outcomes.delete();
         mismatch_count = 0;
      end else begin
         // Compare a returned transaction with the oldest prediction
         if (rsp_valid !== 1'b0) begin
            if (awaited_outcomes.size() == 0) begin
               $error("unexpected result: status %0d read_value %0d", rsp_status,
                      rsp_read_value);
               mismatch_count++;
            end else begin
               want = awaited_outcomes[0];
               awaited_outcomes.delete(0);
               if (rsp_status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_status);
                  mismatch_count++;
               end
               if (rsp_read_value !== want.read_value) begin
                  $error("read_value: expected %0d, got %0d", $signed(want.read_value),
                         rsp_read_value);
                  mismatch_count++;
               end
               if (rsp_now_empty !== want.now_empty) begin
                  $error("now_empty: expected %0d, got %0d", want.now_empty, rsp_now_empty);
                  mismatch_count++;
               end
               if (rsp_now_full !== want.now_full) begin
                  $error("now_full: expected %0d, got %0d", want.now_full, rsp_now_full);
                  mismatch_count++;
               end
            end
         end
         // Predict each accepted request transaction
         if (start === 1'b1 && busy === 1'b0) begin
            awaited_outcomes.insert(awaited_outcomes.size(),
                                    deque_step_outcome(req_action, req_data_value));
         end
         // Track capacity writes and check read-backs
         if (psel === 1'b1 && penable === 1'b1 && pready === 1'b1) begin
            if (pwrite) begin
               if (paddr == cdq_pkg::REG_CAPACITY) begin
                  capacity_reg = pwdata[cdq_pkg::CAP_W-1:0];
                  empty_deque();
               end
            end else if (paddr == cdq_pkg::REG_CAPACITY &&
                         prdata !== cdq_pkg::CSR_W'(capacity_reg)) begin
               $error("capacity: expected %0d, got %0d", capacity_reg, prdata);
               mismatch_count++;
            end
         end
      end
      pending_count = awaited_outcomes.size();
   end

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// Top of the circular deque testbench: clock, reset, request and CSR stimulus.
// Depends on cdq_pkg, circular_deque_unit and deque_checker.
module testbench;

   localparam int unsigned DEPTH        = 16;
   localparam int unsigned CYCLE_LIMIT  = 100000;
   localparam int unsigned PHASES       = 8;
   localparam int unsigned PHASE_ITEMS  = 80;
   localparam int unsigned BIAS_RUN     = 24;
   localparam logic [cdq_pkg::ACTION_W-1:0] ACT_SPARE_A = 3'd6;
   localparam logic [cdq_pkg::ACTION_W-1:0] ACT_SPARE_B = 3'd7;

   // Capacity and sender idle percentage per random phase; the last capacity is drawn
   localparam logic [cdq_pkg::CAP_W-1:0] PHASE_CAPACITY [PHASES] =
      '{5'd16, 5'd1, 5'd0, 5'd31, 5'd2, 5'd17, 5'd5, 5'd3};
   localparam int unsigned PHASE_IDLE [PHASES] = '{0, 82, 32, 0, 82, 32, 82, 0};
   localparam int unsigned PUSH_WEIGHT [3] = '{80, 20, 55};

   logic                                clock          = 1'b0;
   logic                                reset          = 1'b1;
   logic                                start          = 1'b0;
   logic [cdq_pkg::ACTION_W-1:0]        req_action     = '0;
   logic signed [cdq_pkg::WORD_W-1:0]   req_data_value = '0;
   logic                                psel           = 1'b0;
   logic                                penable        = 1'b0;
   logic                                pwrite         = 1'b0;
   logic [cdq_pkg::ADDR_W-1:0]          paddr          = '0;
   logic [cdq_pkg::CSR_W-1:0]           pwdata         = '0;
   logic                                busy;
   logic                                rsp_valid;
   logic [cdq_pkg::STATUS_W-1:0]        rsp_status;
   logic signed [cdq_pkg::WORD_W-1:0]   rsp_read_value;
   logic                                rsp_now_empty;
   logic                                rsp_now_full;
   logic [cdq_pkg::CSR_W-1:0]           prdata;
   logic                                pready;
   int unsigned                         mismatch_count;
   int unsigned                         pending_count;
   int unsigned                         cycle_count    = 0;

   always #10 clock = ~clock;

   circular_deque_unit #(.DEPTH(DEPTH)) dut (
      .clock, .reset, .start, .busy, .req_action, .req_data_value,
      .rsp_valid, .rsp_status, .rsp_read_value, .rsp_now_empty, .rsp_now_full,
      .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
   );

   deque_checker #(.DEPTH(DEPTH)) u_checker (
      .clock, .reset, .start, .busy, .req_action, .req_data_value,
      .rsp_valid, .rsp_status, .rsp_read_value, .rsp_now_empty, .rsp_now_full,
      .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
      .mismatch_count, .pending_count
   );

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // Present one request and hold it until accepted
   task automatic send_item(input logic [cdq_pkg::ACTION_W-1:0] act,
                            input logic [cdq_pkg::WORD_W-1:0]   word);
      start          <= 1'b1;
      req_action     <= act;
      req_data_value <= word;
      do @(posedge clock); while (busy !== 1'b0);
   endtask

   // Drop start for a random number of cycles, with junk on the request fields
   task automatic hold_off(input int unsigned pct);
      while ($urandom_range(0, 99) < pct) begin
         start          <= 1'b0;
         req_action     <= cdq_pkg::ACTION_W'($urandom);
         req_data_value <= $urandom;
         @(posedge clock);
      end
   endtask

   // One APB transfer to the capacity register; psel stays high afterward
   task automatic csr_access(input logic wr, input logic [cdq_pkg::CSR_W-1:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= wr;
      paddr   <= cdq_pkg::REG_CAPACITY;
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
   endtask

   // Drain outstanding results, then write and read back the capacity
   task automatic reconfigure(input logic [cdq_pkg::CAP_W-1:0] cap);
      start <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
      csr_access(1'b1, cdq_pkg::CSR_W'(cap));
      csr_access(1'b0, '0);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   // Mostly pushes or pops by weight, some peeks and a few unused codes
   function automatic logic [cdq_pkg::ACTION_W-1:0] pick_action(
         input int unsigned push_weight);
      int unsigned roll;
      logic        rear;
      roll = $urandom_range(0, 99);
      rear = 1'($urandom);
      if (roll < 5) return rear ? ACT_SPARE_B : ACT_SPARE_A;
      if (roll < 15) return rear ? cdq_pkg::ACT_PEEK_REAR : cdq_pkg::ACT_PEEK_FRONT;
      if ($urandom_range(0, 99) < push_weight) begin
         return rear ? cdq_pkg::ACT_PUSH_REAR : cdq_pkg::ACT_PUSH_FRONT;
      end
      return rear ? cdq_pkg::ACT_POP_REAR : cdq_pkg::ACT_POP_FRONT;
   endfunction

   function automatic logic [cdq_pkg::WORD_W-1:0] pick_word();
      if ($urandom_range(0, 7) != 0) return $urandom;
      case ($urandom_range(0, 3))
         0:       return 32'h8000_0000;
         1:       return 32'h7FFF_FFFF;
         2:       return 32'hFFFF_FFFF;
         default: return 32'h0000_0000;
      endcase
   endfunction

   initial begin
      int unsigned               bias;
      logic [cdq_pkg::CAP_W-1:0] cap;
      bias = PUSH_WEIGHT[0];
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Empty deque: every read is refused, unused codes do nothing
      send_item(cdq_pkg::ACT_POP_FRONT, 32'h1234_5678);
      send_item(cdq_pkg::ACT_POP_REAR, '0);
      send_item(cdq_pkg::ACT_PEEK_FRONT, '0);
      send_item(cdq_pkg::ACT_PEEK_REAR, '0);
      send_item(ACT_SPARE_A, 32'hFFFF_FFFF);
      send_item(ACT_SPARE_B, '0);
      // Extreme words at both ends, then drain down to empty and beyond
      send_item(cdq_pkg::ACT_PUSH_FRONT, 32'h8000_0000);
      send_item(cdq_pkg::ACT_PUSH_REAR, 32'h7FFF_FFFF);
      send_item(cdq_pkg::ACT_PUSH_FRONT, 32'hFFFF_FFFF);
      send_item(cdq_pkg::ACT_PUSH_REAR, 32'h0000_0000);
      send_item(cdq_pkg::ACT_PEEK_FRONT, '0);
      send_item(cdq_pkg::ACT_PEEK_REAR, '0);
      send_item(cdq_pkg::ACT_POP_REAR, '0);
      send_item(cdq_pkg::ACT_POP_FRONT, '0);
      send_item(cdq_pkg::ACT_POP_REAR, '0);
      send_item(cdq_pkg::ACT_POP_FRONT, '0);
      send_item(cdq_pkg::ACT_POP_FRONT, '0);
      // Single slot: one push fills it, the next is refused
      reconfigure(5'd1);
      send_item(cdq_pkg::ACT_PUSH_REAR, 32'h0000_0005);
      send_item(cdq_pkg::ACT_PUSH_FRONT, 32'h0000_0006);
      send_item(cdq_pkg::ACT_PEEK_REAR, '0);
      send_item(cdq_pkg::ACT_POP_REAR, '0);
      send_item(cdq_pkg::ACT_PUSH_FRONT, 32'hCAFE_F00D);
      // Capacity zero acts as one; the write also empties the deque
      reconfigure(5'd0);
      send_item(cdq_pkg::ACT_POP_FRONT, '0);
      send_item(cdq_pkg::ACT_PUSH_REAR, 32'h0BAD_BEEF);
      send_item(cdq_pkg::ACT_PUSH_REAR, 32'h0000_0001);

      // Random phases over capacities and sender idle rates
      for (int p = 0; p < PHASES; p++) begin
         cap = (p == PHASES - 1) ? cdq_pkg::CAP_W'($urandom_range(0, 31))
                                 : PHASE_CAPACITY[p];
         reconfigure(cap);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (n % BIAS_RUN == 0) bias = PUSH_WEIGHT[$urandom_range(0, 2)];
            hold_off(PHASE_IDLE[p]);
            send_item(pick_action(bias), pick_word());
         end
      end

      // Drain and give the verdict
      start <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
      repeat (4) @(posedge clock);
      if (mismatch_count == 0 && pending_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

// ===== circular_deque_unit.f =====
rtl/cdq_pkg.sv
rtl/cdq_cell.sv
rtl/circular_deque_unit.sv
sim/deque_checker.sv
sim/testbench.sv
